[src/rfmt_pkg.sv]
// Shared types, constants and prefix table for the radix line formatter.
// No dependencies; every other file refers to it by scoped names.
package rfmt_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    FMT_LABEL = 2'd0,
    FMT_DEC   = 2'd1,
    FMT_HEX   = 2'd2,
    FMT_BIN   = 2'd3
  } fmt_t;

  typedef struct packed {
    fmt_t        fmt;
    logic [31:0] value;
    logic [7:0]  serial_char;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_CONVERT,
    ST_SKIP,
    ST_DIGITS,
    ST_CR,
    ST_LF
  } state_t;

  localparam logic [7:0] LINE_CR       = 8'h0d;
  localparam logic [7:0] LINE_LF       = 8'h0a;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_HEX_BASE = 8'h37;
  localparam logic [7:0] SERIAL_RESET  = 8'd1;
  localparam logic [3:0] LABEL_DIGIT_POS = 4'd3;
  localparam int         DEC_DIGITS    = 10;
  localparam int         HEX_DIGITS    = 8;
  localparam int         BIN_DIGITS    = 32;
  localparam int         VALUE_W       = 32;
  localparam int         WORK_W        = 4 * DEC_DIGITS;

  localparam logic [7:0] PREFIX_ROM [4][16] = '{
    '{8'hE7, 8'hAC, 8'hAC, 8'h30, 8'hE4, 8'hB8, 8'hAA, 8'hE6,
      8'h95, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hE5, 8'h8D, 8'h81, 8'hE8, 8'hBF, 8'h9B, 8'hE5, 8'h88,
      8'hB6, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hE5, 8'h8D, 8'h81, 8'hE5, 8'h85, 8'hAD, 8'hE8, 8'hBF,
      8'h9B, 8'hE5, 8'h88, 8'hB6, 8'h3A, 8'h00, 8'h00, 8'h00},
    '{8'hE4, 8'hBA, 8'h8C, 8'hE8, 8'hBF, 8'h9B, 8'hE5, 8'h88,
      8'hB6, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [7:0] prefix_byte(fmt_t f, logic [3:0] idx);
    return PREFIX_ROM[f][idx];
  endfunction

  function automatic logic [3:0] prefix_last(fmt_t f);
    logic [3:0] r;
    case (f)
      FMT_HEX: r = 4'd12;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

endpackage

[src/rfmt_front.sv]
// Front end: accepts items, classifies the kind and stamps the serial digit.
// Depends on rfmt_pkg; feeds rfmt_queue.
module rfmt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rfmt_pkg::item_t     item,
  input  logic                q_full,
  output logic                wr_en,
  output rfmt_pkg::cmd_t      cmd
);

  logic [7:0] serial;
  logic [7:0] serial_next;
  rfmt_pkg::fmt_t fmt;

  assign full  = q_full;
  assign wr_en = push && !q_full;

  always_comb begin
    case (item.kind)
      rfmt_pkg::FMT_LABEL: fmt = rfmt_pkg::FMT_LABEL;
      rfmt_pkg::FMT_DEC:   fmt = rfmt_pkg::FMT_DEC;
      rfmt_pkg::FMT_HEX:   fmt = rfmt_pkg::FMT_HEX;
      default:             fmt = rfmt_pkg::FMT_BIN;
    endcase
    serial_next = serial;
    if (wr_en && fmt == rfmt_pkg::FMT_LABEL) begin
      serial_next = serial + 8'd1;
    end
  end

  assign cmd.fmt         = fmt;
  assign cmd.value       = item.value;
  assign cmd.serial_char = serial + rfmt_pkg::CHAR_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      serial <= rfmt_pkg::SERIAL_RESET;
    end else begin
      serial <= serial_next;
    end
  end

endmodule

[src/rfmt_queue.sv]
// Short command queue between the front end and the byte emitter.
// Depends on rfmt_pkg for the command type.
module rfmt_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  rfmt_pkg::cmd_t   wr_data,
  output logic             full,
  input  logic             rd_en,
  output rfmt_pkg::cmd_t   rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfmt_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count over depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en) else $error("write into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    empty |-> !rd_en) else $error("read from empty queue");
`endif

endmodule

[src/rfmt_back.sv]
// Back end: expands one command into prefix, converted digits and CR LF bytes.
// Depends on rfmt_pkg; reads rfmt_queue and drives the result register.
module rfmt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  rfmt_pkg::cmd_t      cmd,
  output logic                empty,
  input  logic                pop,
  output rfmt_pkg::result_t   result
);

  localparam int WW = rfmt_pkg::WORK_W;
  localparam int VW = rfmt_pkg::VALUE_W;

  rfmt_pkg::state_t state, state_next;
  rfmt_pkg::fmt_t   fmt, fmt_next;
  logic [5:0]       cnt, cnt_next;
  logic [WW-1:0]    work, work_next;
  logic [VW-1:0]    bin, bin_next;
  logic [7:0]       serial_char, serial_char_next;
  rfmt_pkg::result_t out_reg, out_reg_next;
  logic             out_valid, out_valid_next;

  logic             emit_ok;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [3:0]       dig;
  logic [7:0]       dig_char;
  logic [WW-1:0]    work_shift;
  logic [WW-1:0]    bcd_adj;

  assign emit_ok = !out_valid || pop;
  assign empty   = !out_valid;
  assign result  = out_reg;

  always_comb begin
    logic [3:0] d;
    dig = (fmt == rfmt_pkg::FMT_BIN) ? {3'b000, work[WW-1]} : work[WW-1 -: 4];
    dig_char = (dig < 4'd10) ? (rfmt_pkg::CHAR_ZERO + {4'h0, dig})
                             : (rfmt_pkg::CHAR_HEX_BASE + {4'h0, dig});
    work_shift = (fmt == rfmt_pkg::FMT_BIN) ? {work[WW-2:0], 1'b0}
                                            : {work[WW-5:0], 4'h0};
    for (int i = 0; i < rfmt_pkg::DEC_DIGITS; i++) begin
      d = work[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    state_next       = state;
    fmt_next         = fmt;
    cnt_next         = cnt;
    work_next        = work;
    bin_next         = bin;
    serial_char_next = serial_char;
    q_pop            = 1'b0;
    emit             = 1'b0;
    emit_byte        = '0;
    emit_last        = 1'b0;
    case (state)
      rfmt_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop            = 1'b1;
          fmt_next         = cmd.fmt;
          serial_char_next = cmd.serial_char;
          bin_next         = cmd.value;
          work_next        = (cmd.fmt == rfmt_pkg::FMT_DEC) ? '0 : {cmd.value, 8'h00};
          cnt_next         = '0;
          state_next       = rfmt_pkg::ST_PREFIX;
        end
      end
      rfmt_pkg::ST_PREFIX: begin
        emit_byte = (fmt == rfmt_pkg::FMT_LABEL && cnt[3:0] == rfmt_pkg::LABEL_DIGIT_POS)
                    ? serial_char : rfmt_pkg::prefix_byte(fmt, cnt[3:0]);
        if (emit_ok) begin
          emit = 1'b1;
          if (cnt[3:0] == rfmt_pkg::prefix_last(fmt)) begin
            case (fmt)
              rfmt_pkg::FMT_LABEL: state_next = rfmt_pkg::ST_CR;
              rfmt_pkg::FMT_DEC: begin
                state_next = rfmt_pkg::ST_CONVERT;
                cnt_next   = '0;
              end
              rfmt_pkg::FMT_HEX: begin
                state_next = rfmt_pkg::ST_SKIP;
                cnt_next   = 6'(rfmt_pkg::HEX_DIGITS);
              end
              default: begin
                state_next = rfmt_pkg::ST_SKIP;
                cnt_next   = 6'(rfmt_pkg::BIN_DIGITS);
              end
            endcase
          end else begin
            cnt_next = cnt + 6'd1;
          end
        end
      end
      rfmt_pkg::ST_CONVERT: begin
        work_next = {bcd_adj[WW-2:0], bin[VW-1]};
        bin_next  = {bin[VW-2:0], 1'b0};
        if (cnt == 6'(VW - 1)) begin
          state_next = rfmt_pkg::ST_SKIP;
          cnt_next   = 6'(rfmt_pkg::DEC_DIGITS);
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      rfmt_pkg::ST_SKIP: begin
        if (cnt > 6'd1 && dig == 4'h0) begin
          work_next = work_shift;
          cnt_next  = cnt - 6'd1;
        end else begin
          state_next = rfmt_pkg::ST_DIGITS;
        end
      end
      rfmt_pkg::ST_DIGITS: begin
        emit_byte = dig_char;
        if (emit_ok) begin
          emit      = 1'b1;
          work_next = work_shift;
          cnt_next  = cnt - 6'd1;
          if (cnt == 6'd1) begin
            state_next = rfmt_pkg::ST_CR;
          end
        end
      end
      rfmt_pkg::ST_CR: begin
        emit_byte = rfmt_pkg::LINE_CR;
        if (emit_ok) begin
          emit       = 1'b1;
          state_next = rfmt_pkg::ST_LF;
        end
      end
      rfmt_pkg::ST_LF: begin
        emit_byte = rfmt_pkg::LINE_LF;
        emit_last = 1'b1;
        if (emit_ok) begin
          emit       = 1'b1;
          state_next = rfmt_pkg::ST_IDLE;
        end
      end
      default: state_next = rfmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_reg_next   = out_reg;
    out_valid_next = out_valid;
    if (emit_ok) begin
      out_valid_next = emit;
      if (emit) begin
        out_reg_next.out_byte = emit_byte;
        out_reg_next.last     = emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfmt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fmt         <= fmt_next;
    cnt         <= cnt_next;
    work        <= work_next;
    bin         <= bin_next;
    serial_char <= serial_char_next;
    out_reg     <= out_reg_next;
  end

`ifndef NO_ASSERTIONS
  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.last) |-> out_reg.out_byte == rfmt_pkg::LINE_LF)
    else $error("last flag on a byte other than line feed");
  a_convert_dec: assert property (@(posedge clk) disable iff (rst)
    state == rfmt_pkg::ST_CONVERT |-> fmt == rfmt_pkg::FMT_DEC)
    else $error("conversion run on a non-decimal line");
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == rfmt_pkg::ST_SKIP || state == rfmt_pkg::ST_DIGITS)
    |-> (cnt != 6'd0 && cnt <= 6'(rfmt_pkg::BIN_DIGITS)))
    else $error("digit count out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == rfmt_pkg::ST_IDLE)
    else $error("command taken while a line is in progress");
`endif

endmodule

[src/radix_ascii_line_formatter_unit.sv]
// Top level of the radix line formatter: front end, command queue, byte emitter.
// Depends on rfmt_pkg, rfmt_front, rfmt_queue and rfmt_back.
//
// Each pushed item (kind, value) becomes one text line popped a byte at a time,
// ending in CR LF with last set on the LF. Kind 0 gives a label line with a
// serial digit that advances per label line; kinds 1..3 give a decimal,
// upper-case hex or binary number after a fixed prefix, leading zeros dropped.
// The emitter takes a command, then sends the prefix bytes one at a time through
// the single result register, which holds while it is full and not popped. On
// number lines a decimal value first passes a 32-step shift-and-add-3 conversion,
// then suppressed leading zeros are skipped before the digits, CR and LF follow.
// QUEUE_DEPTH items may wait ahead of the emitter, so pushes continue while a
// line is being sent.
module radix_ascii_line_formatter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rfmt_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output rfmt_pkg::result_t   result
);

  logic           q_full;
  logic           q_empty;
  logic           q_wr;
  logic           q_rd;
  rfmt_pkg::cmd_t q_wr_data;
  rfmt_pkg::cmd_t q_rd_data;

  rfmt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .wr_en  (q_wr),
    .cmd    (q_wr_data)
  );

  rfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  rfmt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_rd),
    .cmd     (q_rd_data),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
